### rtl/core/sobel_edge_threshold_unit_assert.svh
// ----------------------------------------------------------------------------
// Sobel edge threshold unit: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_THRESHOLD_UNIT_ASSERT_SVH
`define SOBEL_EDGE_THRESHOLD_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SOBET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SOBET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sobet_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
package sobet_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int PIX_W          = 8;
  localparam int DIM_W          = 11;
  localparam int MAG_W          = 21;
  localparam int COORD_W        = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 21;
  localparam int MIN_DIM        = 3;

  localparam logic [DIM_W-1:0] RST_LINE_WIDTH   = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = DIM_W'(480);
  localparam logic [MAG_W-1:0] RST_EDGE_THRESH  = MAG_W'(40000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH     = 2'd0,
    CFG_FRAME_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } sobet_cfg_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } sobet_in_t;

  typedef struct packed {
    logic               edge_res;
    logic [MAG_W-1:0]   mag_sq;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
  } sobet_out_t;

  typedef struct packed {
    logic               valid;
    logic               emit;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } sobet_tag_t;

  typedef logic [2:0][2:0][PIX_W-1:0] sobet_win_t;

endpackage

### rtl/core/sobet_line_store.sv
// ----------------------------------------------------------------------------
// Sobel line store
// Two-line buffer memory with read-modify-write, forwarding and 3x3 window.
// ----------------------------------------------------------------------------
module sobet_line_store import sobet_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AddrW    = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic [PIX_W-1:0] px_i,
  input  sobet_tag_t       tag_i,
  output sobet_win_t       win_o,
  output sobet_tag_t       tag_o
);

  logic [2*PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q;

  sobet_tag_t         s1_tag_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic [PIX_W-1:0]   s1_px_q;

  logic               wr_valid_q;
  logic [AddrW-1:0]   wr_addr_q;
  logic [2*PIX_W-1:0] wr_data_q;

  logic [2*PIX_W-1:0] col_data;
  logic [2*PIX_W-1:0] wr_data;
  sobet_win_t         win_q;
  sobet_tag_t         win_tag_q;

  always_comb begin
    col_data = (wr_valid_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : rdata_q;
    wr_data  = {col_data[PIX_W-1:0], s1_px_q};
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && s1_tag_q.valid) begin
      mem_q[s1_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q   <= '0;
      wr_valid_q <= 1'b0;
      win_tag_q  <= '0;
    end else if (adv_i) begin
      s1_tag_q   <= '{valid: rd_en_i, emit: tag_i.emit, row: tag_i.row, col: tag_i.col};
      wr_valid_q <= s1_tag_q.valid;
      win_tag_q  <= s1_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_addr_q <= rd_addr_i;
      s1_px_q   <= px_i;
      wr_addr_q <= s1_addr_q;
      wr_data_q <= wr_data;
      if (s1_tag_q.valid) begin
        for (int k = 0; k < 3; k++) begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[0][2] <= col_data[2*PIX_W-1:PIX_W];
        win_q[1][2] <= col_data[PIX_W-1:0];
        win_q[2][2] <= s1_px_q;
      end
    end
  end

  assign win_o = win_q;
  assign tag_o = win_tag_q;

endmodule

### rtl/core/sobet_gradient.sv
// ----------------------------------------------------------------------------
// Sobel gradient pipeline
// Column and row sums, absolute values, squares, sum and threshold compare.
// ----------------------------------------------------------------------------
module sobet_gradient import sobet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  sobet_win_t       win_i,
  input  sobet_tag_t       tag_i,
  input  logic [MAG_W-1:0] thresh_i,
  output logic             push_valid_o,
  output sobet_out_t       push_data_o
);

  localparam int SumW = PIX_W + 2;
  localparam int SqW  = 2 * SumW;

  logic [SumW-1:0]   col_r, col_l, row_b, row_t;
  logic signed [SumW:0] gx, gy;
  logic [SumW-1:0]   abs_gx, abs_gy;

  sobet_tag_t        s2_tag_q, s3_tag_q;
  logic [SumW-1:0]   abs_gx_q, abs_gy_q;
  logic [SqW-1:0]    sq_gx_q, sq_gy_q;
  logic [MAG_W-1:0]  mag;

  always_comb begin
    col_r  = SumW'(win_i[0][2]) + {1'b0, win_i[1][2], 1'b0} + SumW'(win_i[2][2]);
    col_l  = SumW'(win_i[0][0]) + {1'b0, win_i[1][0], 1'b0} + SumW'(win_i[2][0]);
    row_b  = SumW'(win_i[2][0]) + {1'b0, win_i[2][1], 1'b0} + SumW'(win_i[2][2]);
    row_t  = SumW'(win_i[0][0]) + {1'b0, win_i[0][1], 1'b0} + SumW'(win_i[0][2]);
    gx     = $signed({1'b0, col_r}) - $signed({1'b0, col_l});
    gy     = $signed({1'b0, row_b}) - $signed({1'b0, row_t});
    abs_gx = gx[SumW] ? SumW'(-gx) : SumW'(gx);
    abs_gy = gy[SumW] ? SumW'(-gy) : SumW'(gy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else if (adv_i) begin
      s2_tag_q <= '{valid: tag_i.valid && tag_i.emit, emit: tag_i.emit,
                    row: tag_i.row, col: tag_i.col};
      s3_tag_q <= s2_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      abs_gx_q <= abs_gx;
      abs_gy_q <= abs_gy;
      sq_gx_q  <= abs_gx_q * abs_gx_q;
      sq_gy_q  <= abs_gy_q * abs_gy_q;
    end
  end

  always_comb begin
    mag                     = MAG_W'(sq_gx_q) + MAG_W'(sq_gy_q);
    push_valid_o            = s3_tag_q.valid;
    push_data_o.edge_res    = (mag > thresh_i);
    push_data_o.mag_sq      = mag;
    push_data_o.center_row  = s3_tag_q.row;
    push_data_o.center_col  = s3_tag_q.col;
  end

endmodule

### rtl/core/sobet_out_buf.sv
// ----------------------------------------------------------------------------
// Sobel output buffer
// Output register with a skid entry; pipeline advance follows skid space.
// ----------------------------------------------------------------------------
module sobet_out_buf import sobet_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  input  sobet_out_t push_data_i,
  input  logic       out_ready_i,
  output logic       adv_o,
  output logic       out_valid_o,
  output sobet_out_t out_data_o
);

  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  sobet_out_t out_data_q, skid_data_q;
  logic       load_out, load_skid, pop_skid;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    load_out     = 1'b0;
    load_skid    = 1'b0;
    pop_skid     = 1'b0;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        pop_skid     = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      load_out    = 1'b1;
      out_valid_d = push_valid_i;
    end else if (push_valid_i) begin
      load_skid    = 1'b1;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_skid) begin
      out_data_q <= skid_data_q;
    end else if (load_out) begin
      out_data_q <= push_data_i;
    end
    if (load_skid) begin
      skid_data_q <= push_data_i;
    end
  end

  assign adv_o       = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/core/sobel_edge_threshold_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold unit
// Streaming 3x3 Sobel gradient with squared-magnitude threshold.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_ready_o   sobet_in_t
//   out       source     out_valid_o / out_ready_i sobet_out_t
//   cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One pixel per clock while in_ready_o is high; a result passes the memory read,
// window, absolute-value and square stages after its lower-right neighbour's
// transfer and then enters the output register.
// Line memory needs no clearing pass after reset; it is written before use.
// in_ready_o drops only while both the output register and skid entry hold
// results; the whole pipeline then holds.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_unit import sobet_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sobet_in_t             in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sobet_out_t            out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  `include "sobel_edge_threshold_unit_assert.svh"

  localparam int ColW  = $clog2(MAX_WIDTH);
  localparam int RowW  = $clog2(MAX_HEIGHT);
  localparam int WBits = ($clog2(MAX_WIDTH + 1) > DIM_W) ? $clog2(MAX_WIDTH + 1) : DIM_W;
  localparam int HBits = ($clog2(MAX_HEIGHT + 1) > DIM_W) ? $clog2(MAX_HEIGHT + 1) : DIM_W;

  logic [DIM_W-1:0] line_width_q, frame_height_q;
  logic [MAG_W-1:0] thresh_q;

  logic [ColW-1:0]  col_q, col_d, c_cur;
  logic [RowW-1:0]  row_q, row_d, r_cur;
  logic             done_q, done_d, done_cur;

  logic [WBits-1:0] eff_w, lw_ext, c_ext;
  logic [HBits-1:0] eff_h, fh_ext, r_ext;
  logic             acc, drop, active, emit;
  logic [31:0]      row_m1, col_m1;

  logic             adv;
  sobet_tag_t       tag_s0, tag_win;
  sobet_win_t       win;
  logic             push_valid;
  sobet_out_t       push_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= RST_LINE_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      thresh_q       <= RST_EDGE_THRESH;
    end else if (cfg_we_i) begin
      case (sobet_cfg_e'(cfg_idx_i))
        CFG_LINE_WIDTH:     line_width_q   <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT:   frame_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_EDGE_THRESHOLD: thresh_q       <= cfg_data_i[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lw_ext = WBits'(line_width_q);
    fh_ext = HBits'(frame_height_q);
    if (lw_ext < WBits'(MIN_DIM)) begin
      eff_w = WBits'(MIN_DIM);
    end else if (lw_ext > WBits'(MAX_WIDTH)) begin
      eff_w = WBits'(MAX_WIDTH);
    end else begin
      eff_w = lw_ext;
    end
    if (fh_ext < HBits'(MIN_DIM)) begin
      eff_h = HBits'(MIN_DIM);
    end else if (fh_ext > HBits'(MAX_HEIGHT)) begin
      eff_h = HBits'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext;
    end

    acc      = in_valid_i && in_ready_o;
    c_cur    = in_data_i.frame_start ? '0 : col_q;
    r_cur    = in_data_i.frame_start ? '0 : row_q;
    done_cur = in_data_i.frame_start ? 1'b0 : done_q;
    c_ext    = WBits'(c_cur);
    r_ext    = HBits'(r_cur);
    drop     = done_cur || (r_ext >= eff_h);
    active   = acc && !drop;
    emit     = (r_ext >= HBits'(2)) && (c_ext >= WBits'(2)) && (c_ext < eff_w);
    row_m1   = 32'(r_cur) - 32'd1;
    col_m1   = 32'(c_cur) - 32'd1;

    col_d  = col_q;
    row_d  = row_q;
    done_d = done_q;
    if (acc) begin
      col_d  = c_cur;
      row_d  = r_cur;
      done_d = done_cur;
      if (drop) begin
        done_d = 1'b1;
      end else if (c_ext + WBits'(1) >= eff_w) begin
        col_d = '0;
        if (r_ext + HBits'(1) >= eff_h) begin
          done_d = 1'b1;
        end else begin
          row_d = r_cur + RowW'(1);
        end
      end else begin
        col_d = c_cur + ColW'(1);
      end
    end

    tag_s0.valid = active;
    tag_s0.emit  = emit;
    tag_s0.row   = row_m1[COORD_W-1:0];
    tag_s0.col   = col_m1[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      done_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      done_q <= done_d;
    end
  end

  sobet_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rd_en_i   (active),
    .rd_addr_i (c_cur),
    .px_i      (in_data_i.pixel),
    .tag_i     (tag_s0),
    .win_o     (win),
    .tag_o     (tag_win)
  );

  sobet_gradient u_gradient (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .win_i        (win),
    .tag_i        (tag_win),
    .thresh_i     (thresh_q),
    .push_valid_o (push_valid),
    .push_data_o  (push_data)
  );

  sobet_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .out_ready_i  (out_ready_i),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .out_data_o   (out_data_o)
  );

  assign in_ready_o = adv;

  `SOBET_ASSERT_IMP(a_hold_implies_full, !in_ready_o, out_valid_o,
                    "input held while output register empty")
  `SOBET_ASSERT_NXT(a_frame_start_restart, acc && in_data_i.frame_start,
                    !done_q && (row_q == '0) && (col_q == ColW'(1)),
                    "frame start did not restart position")

endmodule

### verif/tb_sobel_edge_threshold_unit.sv
// ----------------------------------------------------------------------------
// Sobel edge threshold unit: testbench
// Streams grey frames through the unit and checks every interior-pixel result
// against an in-bench model of the line stores, the 3x3 window and the
// squared-gradient threshold. A short table of hand-worked frames comes first,
// then random frames under several register settings and stall mixes.
// ----------------------------------------------------------------------------
module tb_sobel_edge_threshold_unit;
  import sobet_pkg::*;

  localparam int N_PHASE    = 10;
  localparam int SETTLE_CYC = 8;
  localparam int N_PROBE    = 22;
  localparam int FRAME_CAP  = 72;
  localparam int VQ_AW      = 6;

  typedef struct packed {
    logic             fs;
    logic [PIX_W-1:0] px;
    logic             typed;
    sobet_out_t       want;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  sobet_in_t             in_data;
  logic                  out_valid;
  logic                  out_ready;
  sobet_out_t            out_data;
  logic                  cfg_we;
  sobet_cfg_e            cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned in_gap_pct;
  int unsigned out_gap_pct;
  int unsigned fail_cnt;
  sobet_out_t  verdict_q [1 << VQ_AW];
  int unsigned vq_wr;
  int unsigned vq_rd;
  sobet_out_t  head;

  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [MAG_W-1:0] thresh_reg;
  logic [PIX_W-1:0] line_two [DEF_MAX_WIDTH];
  logic [PIX_W-1:0] line_one [DEF_MAX_WIDTH];
  sobet_win_t       win;
  int unsigned      col_pos;
  int unsigned      row_pos;
  bit               frame_closed;

  probe_row_t probes [N_PROBE] = '{
    // flat black frame, zero threshold
    '{1'b1, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 8'h00, 1'b1, '{1'b0, 21'd0, 10'd1, 10'd1}},
    // past the last row: drop
    '{1'b0, 8'hFF, 1'b0, '0}, '{1'b0, 8'hFF, 1'b0, '0},
    // abandoned frame, restarted
    '{1'b1, 8'h80, 1'b0, '0}, '{1'b0, 8'h4D, 1'b0, '0},
    // corner step
    '{1'b1, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 8'hFF, 1'b1, '{1'b1, 21'd1300500, 10'd1, 10'd1}}
  };

  sobel_edge_threshold_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_dim(input logic [DIM_W-1:0] raw, input int unsigned hi);
    if (raw < MIN_DIM) return MIN_DIM;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void stash_verdict(input sobet_out_t v);
    verdict_q[VQ_AW'(vq_wr)] = v;
    vq_wr++;
  endfunction

  function automatic void judge_pixel(input sobet_in_t item, output bit hit,
                                      output sobet_out_t verdict);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned c;
    int unsigned r;
    int          gx;
    int          gy;
    int          mag;
    w_eff   = eff_dim(width_reg, DEF_MAX_WIDTH);
    h_eff   = eff_dim(height_reg, DEF_MAX_HEIGHT);
    hit     = 1'b0;
    verdict = '0;
    if (item.frame_start) begin
      col_pos      = 0;
      row_pos      = 0;
      frame_closed = 1'b0;
    end
    if (frame_closed || row_pos >= h_eff) begin
      frame_closed = 1'b1;
      return;
    end
    c = col_pos;
    r = row_pos;
    if (c < DEF_MAX_WIDTH) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2]   = line_two[c];
      win[1][2]   = line_one[c];
      win[2][2]   = item.pixel;
      line_two[c] = line_one[c];
      line_one[c] = item.pixel;
    end
    if (r >= 2 && c >= 2 && c < w_eff) begin
      gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
      gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
         - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
      mag                = gx * gx + gy * gy;
      verdict.edge_res   = (mag > int'(thresh_reg));
      verdict.mag_sq     = MAG_W'(mag);
      verdict.center_row = COORD_W'(r - 1);
      verdict.center_col = COORD_W'(c - 1);
      hit                = 1'b1;
    end
    if (c + 1 >= w_eff) begin
      col_pos = 0;
      if (r + 1 >= h_eff) frame_closed = 1'b1;
      else row_pos = r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic write_reg(input sobet_cfg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_LINE_WIDTH: begin
        width_reg = val[DIM_W-1:0];
      end
      CFG_FRAME_HEIGHT: begin
        height_reg = val[DIM_W-1:0];
      end
      default: begin
        thresh_reg = val[MAG_W-1:0];
      end
    endcase
  endtask

  task automatic program_regs(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                              input logic [MAG_W-1:0] thr);
    write_reg(CFG_LINE_WIDTH, {10'($urandom), w});
    write_reg(CFG_FRAME_HEIGHT, {10'($urandom), h});
    write_reg(CFG_EDGE_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_pixel(input sobet_in_t item, input bit typed, input sobet_out_t want);
    sobet_out_t v;
    bit         hit;
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    judge_pixel(item, hit, v);
    if (typed) stash_verdict(want);
    else if (hit) stash_verdict(v);
  endtask

  task automatic drain(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (vq_wr != vq_rd);
    repeat (settle) @(posedge clk);
  endtask

  task automatic stream_frame();
    int unsigned      n;
    int unsigned      cut;
    int unsigned      tail;
    int unsigned      style;
    logic [PIX_W-1:0] base;
    sobet_in_t        item;
    n     = eff_dim(width_reg, DEF_MAX_WIDTH) * eff_dim(height_reg, DEF_MAX_HEIGHT);
    if (n > FRAME_CAP) n = FRAME_CAP;
    cut   = ($urandom_range(9) == 0) ? $urandom_range(1, n - 1) : n;
    tail  = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0;
    style = $urandom_range(2);
    base  = PIX_W'($urandom);
    // hold the stream until the output side has caught up
    if ($urandom_range(7) == 0) drain(0);
    for (int i = 0; i < cut + tail; i++) begin
      case (style)
        0: begin
          item.pixel = PIX_W'($urandom);
        end
        1: begin
          item.pixel = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        default: begin
          item.pixel = {base[7:3], 3'($urandom)};
        end
      endcase
      item.frame_start = (i == 0);
      drive_pixel(item, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (vq_wr == vq_rd) begin
        $error("unexpected transfer: center_row %0d center_col %0d",
               out_data.center_row, out_data.center_col);
        fail_cnt++;
      end else begin
        head = verdict_q[VQ_AW'(vq_rd)];
        vq_rd++;
        if (out_data.edge_res !== head.edge_res) begin
          $error("edge_res: expected %0d, got %0d", head.edge_res, out_data.edge_res);
          fail_cnt++;
        end
        if (out_data.mag_sq !== head.mag_sq) begin
          $error("mag_sq: expected %0d, got %0d", head.mag_sq, out_data.mag_sq);
          fail_cnt++;
        end
        if (out_data.center_row !== head.center_row) begin
          $error("center_row: expected %0d, got %0d", head.center_row, out_data.center_row);
          fail_cnt++;
        end
        if (out_data.center_col !== head.center_col) begin
          $error("center_col: expected %0d, got %0d", head.center_col, out_data.center_col);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [MAG_W-1:0] thr;
    int unsigned      nfr;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_idx     <= CFG_LINE_WIDTH;
    cfg_data    <= '0;
    in_gap_pct   = 34;
    out_gap_pct  = 65;
    fail_cnt     = 0;
    vq_wr        = 0;
    vq_rd        = 0;
    width_reg    = RST_LINE_WIDTH;
    height_reg   = RST_FRAME_HEIGHT;
    thresh_reg   = RST_EDGE_THRESH;
    win          = '0;
    col_pos      = 0;
    row_pos      = 0;
    frame_closed = 1'b0;
    foreach (line_two[i]) begin
      line_two[i] = '0;
      line_one[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // width and height below the floor: both saturate to three
    program_regs(DIM_W'(2), DIM_W'(0), '0);
    foreach (probes[i]) begin
      drive_pixel('{pixel: probes[i].px, frame_start: probes[i].fs},
                  probes[i].typed, probes[i].want);
    end
    drain(SETTLE_CYC);

    for (int ph = 0; ph < N_PHASE; ph++) begin
      in_gap_pct  = (ph < 3) ? 34 : (ph < 6) ? 65 : 0;
      out_gap_pct = (ph < 3) ? 65 : (ph < 6) ? 34 : 0;
      w   = DIM_W'($urandom_range(0, 10));
      h   = DIM_W'($urandom_range(0, 6));
      thr = ($urandom_range(3) == 0) ? MAG_W'($urandom) : MAG_W'($urandom_range(0, 150000));
      nfr = $urandom_range(1, 2);
      case (ph)
        1: begin
          w   = '1;
          h   = DIM_W'(3);
          nfr = 1;
        end
        4: begin
          w   = DIM_W'(3);
          h   = '1;
          thr = '0;
          nfr = 1;
        end
        7: begin
          thr = '1;
        end
        default: begin
        end
      endcase
      program_regs(w, h, thr);
      repeat (nfr) stream_frame();
      drain(SETTLE_CYC);
    end

    if (fail_cnt == 0) begin
      $display("[sobel_edge_threshold_unit] OK");
    end else begin
      $display("[sobel_edge_threshold_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[sobel_edge_threshold_unit] ERROR");
    $finish;
  end

endmodule
